@@ hdl/espi_pkg.sv @@
// ----------------------------------------------------------------------------
// espi_pkg
// Types and constants shared by the encoder speed PI controller modules.
// ----------------------------------------------------------------------------
package espi_pkg;

    // Field widths of the stream items.
    localparam int POS_W   = 32;
    localparam int SET_W   = 8;
    localparam int SPEED_W = 16;
    localparam int ERR_W   = 17;
    localparam int SUM_W   = 24;
    localparam int GAIN_W  = 8;
    localparam int DUTY_W  = 11;

    // Widths of the two gain products and of their sum.
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int DRIVE_W  = PROD_I_W + 1;

    // Reset values of the gain registers.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd30;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd8;

    // Saturation limits of the speed and of the integrator.
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sh8000;
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = 24'sh7FFFFF;
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = -24'sh800000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PROP_GAIN  = 1'b0,
        REG_INTEG_GAIN = 1'b1
    } cfg_reg_t;

    // Payload after the speed stage.
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [SET_W-1:0]   setpoint;
        logic                      clear;
    } speed_item_t;

    // Payload after the integrator stage.
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
    } err_item_t;

endpackage

@@ hdl/encoder_speed_pi_controller_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller_unit
// PI speed controller fed with absolute encoder positions, one tick per item.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one control tick carrying the encoder
// position, a signed speed setpoint and an integrator clear flag. Each tick
// gives exactly one transfer on the output stream with the motor direction
// and the clamped duty magnitude.
// The gains are set through the write port (index 0 proportional gain,
// index 1 integral gain) while no tick is in flight.
// A tick passes four registers: speed, integrator, gain products and the
// result register, which drives the output stream. One tick is accepted
// every cycle while the output is not stalled; both feedback loops, the
// previous position and the integrator, are closed within a single stage.
// Each stage holds its tick only while the next stage is full and stalled,
// so while the receiver stalls, up to four ticks are held and the input
// keeps taking ticks until all stages are full.
// Reset restores the gains to 30 and 8, clears the previous position and the
// integrator, and empties the pipeline.
// ----------------------------------------------------------------------------
module encoder_speed_pi_controller_unit
    import espi_pkg::*;
#(
    parameter int unsigned DUTY_MAX = 2047
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // encoder_position [31:0], speed_setpoint [39:32], clear_integrator [40]
    input  logic [47:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // reverse_dir [0], duty_magnitude [11:1]
    output logic [15:0]       m_axis_tdata,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;

    logic              spd_valid;
    logic              spd_ready;
    speed_item_t       spd_item;
    logic              err_valid;
    logic              err_ready;
    err_item_t         err_item;
    logic              reverse_dir;
    logic [DUTY_W-1:0] duty_magnitude;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    espi_speed u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .position  (s_axis_tdata[31:0]),
        .setpoint  ($signed(s_axis_tdata[39:32])),
        .clear     (s_axis_tdata[40]),
        .out_valid (spd_valid),
        .out_ready (spd_ready),
        .out_item  (spd_item)
    );

    espi_integ u_integ (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (spd_valid),
        .in_ready  (spd_ready),
        .in_item   (spd_item),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_item  (err_item)
    );

    espi_drive #(
        .DUTY_MAX (DUTY_MAX)
    ) u_drive (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (err_valid),
        .in_ready       (err_ready),
        .in_item        (err_item),
        .prop_gain      (prop_gain_reg),
        .integ_gain     (integ_gain_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .reverse_dir    (reverse_dir),
        .duty_magnitude (duty_magnitude)
    );

    assign m_axis_tdata = {4'b0000, duty_magnitude, reverse_dir};

endmodule

@@ hdl/espi_speed.sv @@
// ----------------------------------------------------------------------------
// espi_speed
// Takes the encoder position, forms the wrapped difference from the previous
// position and saturates it to a 16-bit speed.
// ----------------------------------------------------------------------------
module espi_speed
    import espi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [POS_W-1:0]        position,
    input  logic signed [SET_W-1:0] setpoint,
    input  logic                    clear,
    output logic                    out_valid,
    input  logic                    out_ready,
    output speed_item_t             out_item
);

    logic [POS_W-1:0]   last_position_reg;
    logic               valid_reg;
    speed_item_t        item_reg;
    speed_item_t        item_next;
    logic [POS_W-1:0]   diff;
    logic               load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        diff = position - last_position_reg;
        // The difference fits 16 bits only when its top 17 bits agree.
        if (!diff[POS_W-1] && (diff[POS_W-2:SPEED_W-1] != '0))
        begin
            item_next.speed = SPEED_MAX;
        end
        else if (diff[POS_W-1] && (diff[POS_W-2:SPEED_W-1] != '1))
        begin
            item_next.speed = SPEED_MIN;
        end
        else
        begin
            item_next.speed = $signed(diff[SPEED_W-1:0]);
        end
        item_next.setpoint = setpoint;
        item_next.clear    = clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_position_reg <= '0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                last_position_reg <= position;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hdl/espi_integ.sv @@
// ----------------------------------------------------------------------------
// espi_integ
// Forms the speed error and updates the saturating 24-bit integrator.
// ----------------------------------------------------------------------------
module espi_integ
    import espi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  speed_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output err_item_t   out_item
);

    logic                    valid_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0] err_next;
    logic signed [SUM_W-1:0] error_sum_next;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W:0]   total;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        err_next = ERR_W'(in_item.setpoint) - ERR_W'(in_item.speed);
        base     = in_item.clear ? '0 : error_sum_reg;
        total    = (SUM_W+1)'(base) + (SUM_W+1)'(err_next);
        if (total > (SUM_W+1)'(SUM_MAX))
        begin
            error_sum_next = SUM_MAX;
        end
        else if (total < (SUM_W+1)'(SUM_MIN))
        begin
            error_sum_next = SUM_MIN;
        end
        else
        begin
            error_sum_next = total[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            error_sum_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                error_sum_reg <= error_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= err_next;
        end
    end

    // The integrator register doubles as this stage's sum payload.
    assign out_valid    = valid_reg;
    assign out_item.err = err_reg;
    assign out_item.sum = error_sum_reg;

    // A cleared tick leaves exactly its own error in the integrator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_item.clear) |=> (error_sum_reg == SUM_W'($past(err_next))))
        else $error("integrator not restarted from the error on a clear");

endmodule

@@ hdl/espi_drive.sv @@
// ----------------------------------------------------------------------------
// espi_drive
// Multiplies error and integrator by their gains, adds the products, clamps
// the drive and splits it into direction and magnitude in the result register.
// ----------------------------------------------------------------------------
module espi_drive
    import espi_pkg::*;
#(
    parameter int unsigned DUTY_MAX = 2047
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  err_item_t         in_item,
    input  logic [GAIN_W-1:0] prop_gain,
    input  logic [GAIN_W-1:0] integ_gain,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              reverse_dir,
    output logic [DUTY_W-1:0] duty_magnitude
);

    localparam int MAG_W = $clog2(DUTY_MAX + 1);
    localparam logic signed [DRIVE_W-1:0] DRIVE_LIM = DRIVE_W'(DUTY_MAX);

    // Product stage.
    logic                       prod_valid_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic                       prod_ready;
    logic                       prod_load;

    // Result stage.
    logic                       res_valid_reg;
    logic                       dir_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       dir_next;
    logic [MAG_W-1:0]           mag_next;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [DRIVE_W-1:0]  limited;
    logic                       res_load;

    assign prod_ready = !res_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_load  = in_valid && in_ready;
    assign res_load   = prod_valid_reg && prod_ready;

    always_comb
    begin
        drive = DRIVE_W'(prod_p_reg) + DRIVE_W'(prod_i_reg);
        if (drive > DRIVE_LIM)
        begin
            limited = DRIVE_LIM;
        end
        else if (drive < -DRIVE_LIM)
        begin
            limited = -DRIVE_LIM;
        end
        else
        begin
            limited = drive;
        end
        // A zero drive is reported as reverse with zero magnitude.
        if (limited > 0)
        begin
            dir_next = 1'b0;
            mag_next = MAG_W'(limited);
        end
        else
        begin
            dir_next = 1'b1;
            mag_next = MAG_W'(-limited);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_p_reg <= $signed({1'b0, prop_gain}) * in_item.err;
            prod_i_reg <= $signed({1'b0, integ_gain}) * in_item.sum;
        end
        if (res_load)
        begin
            dir_reg <= dir_next;
            mag_reg <= mag_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign reverse_dir    = dir_reg;
    assign duty_magnitude = DUTY_W'(mag_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (32'(mag_reg) <= DUTY_MAX))
        else $error("duty magnitude beyond the clamp limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !dir_reg) |-> (mag_reg != '0))
        else $error("forward direction with zero magnitude");

endmodule

@@ dv/encoder_speed_pi_controller_unit_tb.sv @@
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller_unit_tb
// Self-checking bench for the encoder speed PI controller.
// ----------------------------------------------------------------------------
// Control ticks are queued by the stimulus process and sent on the input
// stream by a clocked driver. Every accepted tick runs through a local copy of
// the speed, integrator and drive arithmetic. The expected direction and duty
// are then checked against the output stream in order. Directed ticks cover
// the first tick after reset, position wrap, speed saturation and zero drive.
// Long runaway sequences push the integrator into both of its limits. Random
// ticks follow under several gain settings and handshake gap patterns.
// ----------------------------------------------------------------------------
module encoder_speed_pi_controller_unit_tb
    import espi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUTY_LIMIT  = 2047;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_TICKS = 160;
    localparam int WINDUP_TICKS = 270;

    typedef struct packed {
        logic                    clear;
        logic signed [SET_W-1:0] setpoint;
        logic [POS_W-1:0]        pos;
    } tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] mag;
        logic              dir;
    } drive_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic              cfg_we = 1'b0;
    logic [0:0]        cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;

    // Stimulus side.
    tick_t       ticks_to_send[$];
    drive_t      duty_due[$];
    int          src_gap_pct = 0;
    int          sink_stall_pct = 0;
    bit          hold_sender = 1'b0;
    logic        tick_taken = 1'b0;
    logic [31:0] stim_pos = '0;

    // Controller state as the bench sees it.
    logic [POS_W-1:0]  pred_last_pos = '0;
    longint            pred_integ = 0;
    logic [GAIN_W-1:0] kp_now = PROP_GAIN_RST;
    logic [GAIN_W-1:0] ki_now = INTEG_GAIN_RST;

    int ticks_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int speed_clamps = 0;
    int integ_clamps = 0;
    int zero_drives = 0;
    int quiet_cycles = 0;

    encoder_speed_pi_controller_unit #(
        .DUTY_MAX(DUTY_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic drive_t predict_drive(tick_t t);
        logic [POS_W-1:0] diff;
        longint           speed;
        longint           err;
        longint           sum;
        longint           drv;
        drive_t           r;
        diff = t.pos - pred_last_pos;
        speed = longint'($signed(diff));
        if (speed > longint'(SPEED_MAX) || speed < longint'(SPEED_MIN))
            speed_clamps++;
        if (speed > longint'(SPEED_MAX))
            speed = longint'(SPEED_MAX);
        else if (speed < longint'(SPEED_MIN))
            speed = longint'(SPEED_MIN);
        pred_last_pos = t.pos;
        err = longint'($signed(t.setpoint)) - speed;
        sum = t.clear ? 0 : pred_integ;
        sum = sum + err;
        if (sum > longint'(SUM_MAX) || sum < longint'(SUM_MIN))
            integ_clamps++;
        if (sum > longint'(SUM_MAX))
            sum = longint'(SUM_MAX);
        else if (sum < longint'(SUM_MIN))
            sum = longint'(SUM_MIN);
        pred_integ = sum;
        drv = longint'(kp_now) * err + longint'(ki_now) * sum;
        if (drv > DUTY_LIMIT)
            drv = DUTY_LIMIT;
        else if (drv < -DUTY_LIMIT)
            drv = -DUTY_LIMIT;
        if (drv == 0)
            zero_drives++;
        // Zero drive is reported as reverse with no duty.
        r.dir = (drv > 0) ? 1'b0 : 1'b1;
        r.mag = DUTY_W'((drv > 0) ? drv : -drv);
        return r;
    endfunction

    // Input driver: a tick held on the bus stays until it is taken.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || tick_taken)
        begin
            if (ticks_to_send.size() > 0 && !hold_sender &&
                $urandom_range(99) >= src_gap_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, ticks_to_send[0]};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: tracks gain writes, predicts each tick and checks each result.
    always @(posedge clk)
    begin : monitor
        drive_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PROP_GAIN)
                    kp_now = cfg_data;
                else if (cfg_index == REG_INTEG_GAIN)
                    ki_now = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (duty_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no tick outstanding: dir %0b duty %0d",
                                 $realtime, m_axis_tdata[0], m_axis_tdata[11:1]);
                end
                else
                begin
                    want = duty_due.pop_front();
                    if (m_axis_tdata[0] !== want.dir || m_axis_tdata[11:1] !== want.mag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d: expected dir %0b duty %0d,",
                                      " got dir %0b duty %0d"},
                                     $realtime, results_checked, want.dir, want.mag,
                                     m_axis_tdata[0], m_axis_tdata[11:1]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                duty_due.push_back(predict_drive(ticks_to_send.pop_front()));
                ticks_sent++;
                tick_taken <= 1'b1;
            end
            else
            begin
                tick_taken <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transfer on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("encoder_speed_pi_controller_unit_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic send_tick(logic [31:0] pos, logic signed [7:0] sp, logic clr);
        tick_t t;
        t.pos = pos;
        t.setpoint = sp;
        t.clear = clr;
        stim_pos = pos;
        ticks_to_send.push_back(t);
    endtask

    task automatic write_gain(cfg_reg_t idx, logic [GAIN_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Returns once every queued tick has been sent and every result checked,
    // plus a margin for the four pipeline stages.
    task automatic wait_for_quiet();
        do
            @(posedge clk);
        while (ticks_to_send.size() != 0 || s_axis_tvalid || duty_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Runaway motion drives the speed into saturation so that the
    // integrator climbs to its limit and stays there for a while.
    task automatic queue_windup(bit upward);
        for (int i = 0; i < WINDUP_TICKS; i++)
        begin
            if (upward)
                send_tick(stim_pos - 32'h0001_0000, 8'sd127, i == 0);
            else
                send_tick(stim_pos + 32'h0001_0000, -8'sd128, i == 0);
        end
    endtask

    task automatic queue_random_tick();
        int          kind;
        int          delta;
        logic [31:0] pos;
        logic [7:0]  sp;
        kind  = $urandom_range(99);
        delta = int'($urandom_range(600)) - 300;
        sp    = 8'($urandom_range(255));
        if (kind < 70)
            pos = stim_pos + 32'(delta);
        else if (kind < 85)
            pos = stim_pos + $urandom();
        else
            pos = $urandom();
        send_tick(pos, $signed(sp), $urandom_range(99) < 10);
    endtask

    initial
    begin
        logic [GAIN_W-1:0] kp_plan[4];
        logic [GAIN_W-1:0] ki_plan[4];
        int                gap_plan[4];
        int                stall_plan[4];
        kp_plan    = '{8'd255, 8'd0, 8'd1, 8'd0};
        ki_plan    = '{8'd0, 8'd255, 8'd1, 8'd0};
        gap_plan   = '{0, 45, 0, 35};
        stall_plan = '{0, 0, 45, 35};
        kp_plan[3] = 8'($urandom_range(255));
        ki_plan[3] = 8'($urandom_range(255));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed ticks under the reset gains.
        send_tick(32'd100, 8'sd0, 1'b0);
        send_tick(32'd100, 8'sd0, 1'b1);
        send_tick(32'd103, 8'sd3, 1'b0);
        send_tick(32'd104, 8'sd2, 1'b0);
        send_tick(32'd104, 8'sd0, 1'b0);
        send_tick(32'd105, -8'sd128, 1'b0);
        send_tick(32'd105, 8'sd127, 1'b0);
        send_tick(32'h7FFF_FFF0, 8'sd127, 1'b1);
        send_tick(32'h8000_0010, -8'sd128, 1'b1);
        send_tick(32'hFFFF_FFF0, 8'sd0, 1'b1);
        send_tick(32'h0000_0005, 8'sd0, 1'b1);
        send_tick(32'h8000_0005, 8'sd0, 1'b1);
        send_tick(32'h0000_0005, -8'sd128, 1'b0);
        send_tick(32'h0000_0005, 8'sd127, 1'b0);
        send_tick(32'hFFFF_FFFF, -8'sd1, 1'b1);
        send_tick(32'h0000_0000, 8'sd1, 1'b0);
        send_tick(32'h0000_8000, 8'sd0, 1'b1);
        send_tick(32'h0000_0000, 8'sd0, 1'b1);
        send_tick(32'hFFFF_7FFF, 8'sd0, 1'b1);
        send_tick(32'hFFFF_7FFF, 8'sd0, 1'b1);
        send_tick(32'h0000_7FFF, -8'sd1, 1'b0);
        wait_for_quiet();

        for (int p = 0; p < 4; p++)
        begin
            write_gain(REG_PROP_GAIN, kp_plan[p]);
            write_gain(REG_INTEG_GAIN, ki_plan[p]);
            src_gap_pct    = gap_plan[p];
            sink_stall_pct = stall_plan[p];
            if (p == 1)
                queue_windup(1'b1);
            else if (p == 2)
                queue_windup(1'b0);
            for (int i = 0; i < RANDOM_TICKS; i++)
                queue_random_tick();
            // Pause the sender mid-stream until the pipeline has drained.
            do
                @(posedge clk);
            while (ticks_to_send.size() > 40);
            hold_sender = 1'b1;
            do
                @(posedge clk);
            while (s_axis_tvalid || duty_due.size() != 0);
            hold_sender = 1'b0;
            wait_for_quiet();
        end

        $display("%0d ticks over four gap patterns and five gain settings; %0d results checked",
                 ticks_sent, results_checked);
        $display("speed clamps %0d, integrator clamps %0d, zero drives %0d, mismatches %0d",
                 speed_clamps, integ_clamps, zero_drives, mismatches);
        if (mismatches == 0)
            $display("encoder_speed_pi_controller_unit_tb: done, clean");
        else
            $display("encoder_speed_pi_controller_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/espi_pkg.sv
hdl/espi_speed.sv
hdl/espi_integ.sv
hdl/espi_drive.sv
hdl/encoder_speed_pi_controller_unit.sv
dv/encoder_speed_pi_controller_unit_tb.sv
